// File: hw/rtl/rxs_pkg.sv
`timescale 1ns / 1ps

package rxs_pkg;

  // field widths of one record
  localparam int NAME_W  = 64;
  localparam int SCORE_W = 32;
  localparam int ID_W    = 32;

  // default store depth
  localparam int DEF_MAX_RECORDS = 32;

  // register codes
  localparam logic MODE_NAME  = 1'b0;
  localparam logic MODE_SCORE = 1'b1;

  // one stored record
  typedef struct packed {
    logic [NAME_W-1:0]  name;
    logic [SCORE_W-1:0] score;
    logic [ID_W-1:0]    id;
  } rec_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_LOAD,
    S_RD_I,
    S_LD_I,
    S_CMP,
    S_WB,
    S_EMIT
  } state_t;

endpackage

// File: hw/rtl/record_exchange_sorter.sv
`timescale 1ns / 1ps
// channel  | ports                                         | direction
// in       | in_valid/in_ready, in_name_text, in_score_text,| record in
//          | in_id_text, in_last_record                    |
// out      | out_valid/out_ready, out_name, out_score,     | sorted record out
//          | out_id, out_last, out_records_dropped         |
// cfg      | cfg_valid/cfg_ready, cfg_data                 | sort mode write
//
// Records load one per cycle into the record store.
// After the last item, the sort runs one compare per cycle through the shared
// comparator and the store's one read and one write port; emission then gives
// one item per cycle while out_ready is high.
// rst_n is synchronous; it clears control registers, not the store or indexes.
// in_ready is low from the last item until the final result is taken;
// out_ready low holds the current result and pauses the read-out.
module record_exchange_sorter #(
  parameter int MAX_RECORDS = rxs_pkg::DEF_MAX_RECORDS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [rxs_pkg::NAME_W-1:0]   in_name_text,
  input  logic [rxs_pkg::SCORE_W-1:0]  in_score_text,
  input  logic [rxs_pkg::ID_W-1:0]     in_id_text,
  input  logic                         in_last_record,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [rxs_pkg::NAME_W-1:0]   out_name,
  output logic [rxs_pkg::SCORE_W-1:0]  out_score,
  output logic [rxs_pkg::ID_W-1:0]     out_id,
  output logic                         out_last,
  output logic                         out_records_dropped,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic                         cfg_data
);
  import rxs_pkg::*;

  localparam int ADDR_W = $clog2(MAX_RECORDS);
  localparam int CNT_W  = $clog2(MAX_RECORDS + 1);

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              drop_r, drop_nxt;
  logic [ADDR_W-1:0] i_r, i_nxt;
  logic [ADDR_W-1:0] j_r, j_nxt;
  logic [CNT_W-1:0]  k_r, k_nxt;
  rec_t              held_r, held_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_last_r, out_last_nxt;
  logic              mode_r;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  rec_t              wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  rec_t              rd_data;

  logic              in_fire, out_fire, has_room, swap, emit_issue;
  logic [CNT_W-1:0]  cnt_after;
  logic [ADDR_W-1:0] last_idx;
  rec_t              in_rec;

  rxs_store #(
    .DEPTH  (MAX_RECORDS),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // handshake and shared compare
  assign in_ready   = (state_r == S_LOAD);
  assign cfg_ready  = 1'b1;
  assign in_fire    = in_valid && in_ready;
  assign out_fire   = out_valid_r && out_ready;
  assign has_room   = (cnt_r < CNT_W'(MAX_RECORDS));
  assign cnt_after  = has_room ? cnt_r + CNT_W'(1) : cnt_r;
  assign last_idx   = ADDR_W'(cnt_r - CNT_W'(1));
  assign swap       = (mode_r == MODE_SCORE) ? (held_r.score < rd_data.score)
                                             : (held_r.name > rd_data.name);
  assign emit_issue = (k_r != cnt_r) && (!out_valid_r || out_ready);
  assign in_rec     = '{name: in_name_text, score: in_score_text, id: in_id_text};

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_LOAD: begin
        if (in_fire && in_last_record) begin
          state_nxt = (cnt_after >= CNT_W'(2)) ? S_RD_I : S_EMIT;
        end
      end
      S_RD_I: state_nxt = S_LD_I;
      S_LD_I: state_nxt = S_CMP;
      S_CMP: begin
        if (j_r == last_idx) begin
          state_nxt = S_WB;
        end
      end
      S_WB: begin
        state_nxt = (i_r + ADDR_W'(1) == last_idx) ? S_EMIT : S_RD_I;
      end
      S_EMIT: begin
        if (out_fire && out_last_r) begin
          state_nxt = S_LOAD;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  // datapath and store port control
  always_comb begin
    cnt_nxt       = cnt_r;
    drop_nxt      = drop_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    held_nxt      = held_r;
    out_valid_nxt = out_valid_r;
    out_last_nxt  = out_last_r;
    wr_en         = 1'b0;
    wr_addr       = cnt_r[ADDR_W-1:0];
    wr_data       = in_rec;
    rd_en         = 1'b0;
    rd_addr       = i_r;
    case (state_r)
      S_LOAD: begin
        if (in_fire) begin
          cnt_nxt = cnt_after;
          if (has_room) begin
            wr_en = 1'b1;
          end else begin
            drop_nxt = 1'b1;
          end
          i_nxt = '0;
          k_nxt = '0;
        end
      end
      S_RD_I: begin
        rd_en = 1'b1;
      end
      S_LD_I: begin
        held_nxt = rd_data;
        rd_en    = 1'b1;
        rd_addr  = i_r + ADDR_W'(1);
        j_nxt    = i_r + ADDR_W'(1);
      end
      S_CMP: begin
        // held record sits at position i, read data is position j
        if (swap) begin
          wr_en    = 1'b1;
          wr_addr  = j_r;
          wr_data  = held_r;
          held_nxt = rd_data;
        end
        if (j_r != last_idx) begin
          rd_en   = 1'b1;
          rd_addr = j_r + ADDR_W'(1);
          j_nxt   = j_r + ADDR_W'(1);
        end
      end
      S_WB: begin
        wr_en   = 1'b1;
        wr_addr = i_r;
        wr_data = held_r;
        i_nxt   = i_r + ADDR_W'(1);
      end
      S_EMIT: begin
        // read data register doubles as the output register
        if (emit_issue) begin
          rd_en         = 1'b1;
          rd_addr       = k_r[ADDR_W-1:0];
          k_nxt         = k_r + CNT_W'(1);
          out_valid_nxt = 1'b1;
          out_last_nxt  = (k_r == cnt_r - CNT_W'(1));
        end else if (out_ready) begin
          out_valid_nxt = 1'b0;
        end
        if (out_fire && out_last_r) begin
          cnt_nxt  = '0;
          drop_nxt = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      cnt_r       <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
      mode_r      <= MODE_NAME;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        mode_r <= cfg_data;
      end
    end
  end

  // indexes and held record
  always_ff @(posedge clk) begin
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    k_r        <= k_nxt;
    held_r     <= held_nxt;
    out_last_r <= out_last_nxt;
  end

  // result ports
  assign out_valid           = out_valid_r;
  assign out_name            = rd_data.name;
  assign out_score           = rd_data.score;
  assign out_id              = rd_data.id;
  assign out_last            = out_last_r;
  assign out_records_dropped = drop_r;

  // no result pending while records load
  a_idle_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid_r)
    else $error("result pending during load");

  // final result taken returns to loading
  a_last_to_load: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ready && out_last_r) |=> (in_ready && cnt_r == '0 && !drop_r))
    else $error("set not closed after final result");

  // record count never passes the store depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_RECORDS))
    else $error("record count overflow");

  // sort passes produce no results
  a_sort_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD_I || state_r == S_LD_I || state_r == S_CMP || state_r == S_WB)
      |-> !out_valid_r)
    else $error("result during sort");

  // the store is written only at a loaded position
  a_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && state_r != S_LOAD) |-> (CNT_W'(wr_addr) < cnt_r))
    else $error("store write beyond loaded records");

endmodule

// File: hw/rtl/rxs_store.sv
`timescale 1ns / 1ps

module rxs_store #(
  parameter int DEPTH  = rxs_pkg::DEF_MAX_RECORDS,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  rxs_pkg::rec_t     wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output rxs_pkg::rec_t     rd_data
);
  import rxs_pkg::*;

  rec_t mem [DEPTH];
  rec_t rd_data_r;

  // single write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // single read port, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: bench/record_exchange_sorter_tb.sv
`timescale 1ns / 1ps

module record_exchange_sorter_tb;
  import rxs_pkg::*;

  localparam int DEPTH       = DEF_MAX_RECORDS;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE      = 8;

  // one expected sorted record
  typedef struct packed {
    rec_t rec;
    logic last;
    logic dropped;
  } sorted_rec_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [NAME_W-1:0]  in_name_text = '0;
  logic [SCORE_W-1:0] in_score_text = '0;
  logic [ID_W-1:0]    in_id_text = '0;
  logic               in_last_record = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [NAME_W-1:0]  out_name;
  logic [SCORE_W-1:0] out_score;
  logic [ID_W-1:0]    out_id;
  logic               out_last;
  logic               out_records_dropped;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic               cfg_data = 1'b0;

  // shadow of the block's store and mode
  rec_t        shadow_store [DEPTH];
  int          shadow_count;
  logic        shadow_drop;
  logic        shadow_mode;
  sorted_rec_t sorted_q [$];

  int errors;
  int cycle_count;
  bit quiet;

  record_exchange_sorter dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_name_text        (in_name_text),
    .in_score_text       (in_score_text),
    .in_id_text          (in_id_text),
    .in_last_record      (in_last_record),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_name            (out_name),
    .out_score           (out_score),
    .out_id              (out_id),
    .out_last            (out_last),
    .out_records_dropped (out_records_dropped),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_data            (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("record_exchange_sorter test failed");
      $finish;
    end
  end

  // store one record; on the last mark sort, queue the whole set and clear
  task automatic absorb_record(input rec_t r, input logic lst);
    rec_t tmp;
    sorted_rec_t e;
    logic swap;
    if (shadow_count < DEPTH) begin
      shadow_store[shadow_count] = r;
      shadow_count++;
    end else begin
      shadow_drop = 1'b1;
    end
    if (lst) begin
      for (int i = 0; i + 1 < shadow_count; i++) begin
        for (int j = i + 1; j < shadow_count; j++) begin
          if (shadow_mode == MODE_SCORE)
            swap = shadow_store[i].score < shadow_store[j].score;
          else
            swap = shadow_store[i].name > shadow_store[j].name;
          if (swap) begin
            tmp = shadow_store[i];
            shadow_store[i] = shadow_store[j];
            shadow_store[j] = tmp;
          end
        end
      end
      for (int i = 0; i < shadow_count; i++) begin
        e.rec = shadow_store[i];
        e.last = (i + 1 == shadow_count);
        e.dropped = shadow_drop;
        sorted_q.push_back(e);
      end
      shadow_count = 0;
      shadow_drop = 1'b0;
    end
  endtask

  // text of up to nbytes characters, first most significant, or any bit pattern
  function automatic logic [63:0] rand_text(input int nbytes);
    logic [63:0] v;
    int len;
    v = '0;
    case ($urandom_range(0, 2))
      0: v = {$urandom, $urandom};
      1: begin
        // few letters so that equal keys turn up often
        len = $urandom_range(1, nbytes);
        for (int k = 0; k < len; k++)
          v = (v << 8) | 64'($urandom_range(8'h61, 8'h63));
        v = v << (8 * (nbytes - len));
      end
      default: begin
        // zero bytes between a leading and a trailing character
        v = (64'($urandom_range(1, 3)) << (8 * (nbytes - 1))) | 64'($urandom_range(0, 3));
      end
    endcase
    if (nbytes < 8)
      v = v & ((64'd1 << (8 * nbytes)) - 64'd1);
    return v;
  endfunction

  // send one item after a random gap; valid stays high for a back-to-back item
  task automatic send_record(input logic [NAME_W-1:0] nm, input logic [SCORE_W-1:0] sc,
                             input logic [ID_W-1:0] id, input logic lst);
    int gap;
    rec_t r;
    gap = quiet ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_name_text   <= nm;
    in_score_text  <= sc;
    in_id_text     <= id;
    in_last_record <= lst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r.name  = nm;
    r.score = sc;
    r.id    = id;
    absorb_record(r, lst);
  endtask

  // stop sending and let the block drain before touching the register
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sorted_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_mode(input logic m);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    shadow_mode = m;
  endtask

  task automatic check_field(input string what, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
      errors++;
    end
  endtask

  // result side stalls
  initial begin
    int stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!(out_valid && out_ready)) @(posedge clk);
    end
  end

  // compare each item taken from the result channel
  always @(posedge clk) begin : check_out
    sorted_rec_t want;
    if (rst_n && out_valid && out_ready) begin
      if (sorted_q.size() == 0) begin
        $display("%0t: unexpected item, actual name %h score %h id %h", $time,
                 out_name, out_score, out_id);
        errors++;
      end else begin
        want = sorted_q.pop_front();
        check_field("out_name", want.rec.name, out_name);
        check_field("out_score", 64'(want.rec.score), 64'(out_score));
        check_field("out_id", 64'(want.rec.id), 64'(out_id));
        check_field("out_last", 64'(want.last), 64'(out_last));
        check_field("out_records_dropped", 64'(want.dropped), 64'(out_records_dropped));
      end
    end
  end

  // name order after reset: extremes, bytes past a zero byte, equal names
  task automatic test_name_order();
    send_record(64'hFFFF_FFFF_FFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
    send_record(64'h0000_0000_0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
    send_record(64'h4100_5A00_0000_0000, 32'h3930_0000, 32'h6964_3031, 1'b0);
    send_record(64'h4100_4200_0000_0000, 32'h3930_0000, 32'h6964_3032, 1'b0);
    send_record(64'h626F_6200_0000_0000, 32'h3530_0000, 32'h6964_3033, 1'b0);
    send_record(64'h626F_6200_0000_0000, 32'h3630_0000, 32'h6964_3034, 1'b1);
  endtask

  task automatic test_single_record();
    send_record(64'h736F_6C6F_0000_0000, 32'h3737_0000, 32'h6964_3035, 1'b1);
  endtask

  // score order: extremes, equal scores, shorter text against longer
  task automatic test_score_order();
    settle();
    write_mode(MODE_SCORE);
    send_record(64'h6161_0000_0000_0000, 32'h0000_0000, 32'h0000_0001, 1'b0);
    send_record(64'h6262_0000_0000_0000, 32'hFFFF_FFFF, 32'h0000_0002, 1'b0);
    send_record(64'h6363_0000_0000_0000, 32'h3735_0000, 32'h0000_0003, 1'b0);
    send_record(64'h6464_0000_0000_0000, 32'h3735_0000, 32'h0000_0004, 1'b0);
    send_record(64'h6565_0000_0000_0000, 32'h3800_0000, 32'h0000_0005, 1'b0);
    send_record(64'h6666_0000_0000_0000, 32'h3130_3000, 32'h0000_0006, 1'b1);
  endtask

  // a full store, and the last-marked item itself is one too many
  task automatic test_store_full();
    settle();
    write_mode(MODE_NAME);
    for (int k = 0; k <= DEPTH; k++)
      send_record(rand_text(8), 32'(rand_text(4)), 32'(rand_text(4)), k == DEPTH);
  endtask

  // random sets, mostly short, now and then past capacity
  task automatic test_random_sets();
    int sent;
    int size;
    sent = 0;
    while (sent < 50) begin
      if ($urandom_range(0, 3) == 0) begin
        settle();
        write_mode($urandom_range(0, 1) ? MODE_SCORE : MODE_NAME);
      end
      quiet = ($urandom_range(0, 4) == 0);
      size = ($urandom_range(0, 9) == 0) ? $urandom_range(DEPTH + 1, DEPTH + 3)
                                         : $urandom_range(1, 8);
      for (int k = 0; k < size; k++)
        send_record(rand_text(8), 32'(rand_text(4)), 32'(rand_text(4)), k == size - 1);
      sent += size;
    end
    quiet = 1'b0;
  endtask

  initial begin
    errors = 0;
    cycle_count = 0;
    quiet = 1'b0;
    shadow_count = 0;
    shadow_drop = 1'b0;
    shadow_mode = MODE_NAME;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_name_order();
    test_single_record();
    test_score_order();
    test_store_full();
    test_random_sets();

    settle();
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("record_exchange_sorter test passed");
    else
      $display("record_exchange_sorter test failed");
    $finish;
  end

endmodule
